[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks on clk_i / rst_ni, left empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/mca_pkg.sv]
// ---------------------------------------------------------------------------
// mca_pkg
// Shared types and constants of the modular coefficient ALU.
// ---------------------------------------------------------------------------
`default_nettype none

package mca_pkg;

  localparam int unsigned MOD_W   = 31;
  localparam int unsigned COEF_W  = 32;
  localparam int unsigned MAX_TERMS = 4;

  localparam logic [MOD_W-1:0] MOD_RESET = 31'd8380417;

  typedef enum logic [1:0] {
    MODE_MUL = 2'd0,
    MODE_ADD = 2'd1,
    MODE_SUB = 2'd2,
    MODE_DOT = 2'd3
  } mode_e;

  typedef enum logic {
    REG_MODULUS     = 1'b0,
    REG_DOT_MODULUS = 1'b1
  } reg_idx_e;

  // sideband that rides along the remainder pipeline
  typedef struct packed {
    logic              neg;
    logic              zero;
    mode_e             mode;
    logic [MOD_W-1:0]  modulus;
    logic [COEF_W-1:0] low;
  } mca_ctl_t;

endpackage

`default_nettype wire

[rtl/mca_rem.sv]
// ---------------------------------------------------------------------------
// mca_rem
// Pipelined truncating remainder: one restoring step per stage.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mca_rem
  import mca_pkg::*;
#(
  parameter int unsigned W = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic signed [W-1:0] dividend_i,
  input  wire logic [MOD_W-1:0]    modulus_i,
  input  wire mode_e               mode_i,
  output logic                     valid_o,
  output logic [COEF_W-1:0]        rem_o,
  output mode_e                    mode_o
);

  logic     [W+1:0]      vld_q;
  mca_ctl_t              ctl_q [W+1];
  logic     [W-1:0]      mag_q [W+1];
  logic     [MOD_W-1:0]  rem_q [W+1];
  logic     [MOD_W-1:0]  rem_d [W];
  logic     [COEF_W-1:0] res_q;
  mca_ctl_t              out_ctl_q;
  logic     [COEF_W-1:0] res_d;
  logic     [COEF_W-1:0] res_abs;

  // valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[W:0], valid_i};
    end
  end

  // entry: sign and magnitude
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q[0].neg     <= dividend_i[W-1];
      ctl_q[0].zero    <= (modulus_i == '0);
      ctl_q[0].mode    <= mode_i;
      ctl_q[0].modulus <= modulus_i;
      ctl_q[0].low     <= dividend_i[COEF_W-1:0];
      mag_q[0]         <= dividend_i[W-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_q[0]         <= '0;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [MOD_W:0] trial;
    assign trial    = {rem_q[k], mag_q[k][W-1]};
    assign rem_d[k] = (trial >= {1'b0, ctl_q[k].modulus}) ?
                      MOD_W'(trial - {1'b0, ctl_q[k].modulus}) : trial[MOD_W-1:0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctl_q[k+1] <= ctl_q[k];
        mag_q[k+1] <= mag_q[k] << 1;
        rem_q[k+1] <= rem_d[k];
      end
    end
  end

  // sign fixup; zero modulus passes the dividend's low word
  always_comb begin
    if (ctl_q[W].zero) begin
      res_d = ctl_q[W].low;
    end else if (ctl_q[W].neg) begin
      res_d = ~{1'b0, rem_q[W]} + 1'b1;
    end else begin
      res_d = {1'b0, rem_q[W]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q     <= res_d;
      out_ctl_q <= ctl_q[W];
    end
  end

  assign valid_o = vld_q[W+1];
  assign rem_o   = res_q;
  assign mode_o  = out_ctl_q.mode;

  assign res_abs = res_q[COEF_W-1] ? (~res_q + 1'b1) : res_q;

  `ASSERT_IMPLY(a_rem_below_mod, valid_o && !out_ctl_q.zero,
                res_abs < {1'b0, out_ctl_q.modulus})
  `ASSERT_IMPLY(a_rem_sign, valid_o && !out_ctl_q.zero && !out_ctl_q.neg,
                !res_q[COEF_W-1])
  `ASSERT_NEXT(a_rem_stall_hold, !en_i, $stable(res_q) && $stable(vld_q))

endmodule

`default_nettype wire

[rtl/modular_coefficient_alu_core.sv]
// Pipeline from input word accepted to result word shown: 2 operand stages,
//   66-stage lane remainder, sum stage, 37-stage final remainder.
// Throughput: one word per cycle; the whole pipeline advances together and
//   holds only while the output word is valid and not taken.
// Reset (rst_ni low, async): clears all valid bits; both moduli return to 8380417.
// ---------------------------------------------------------------------------
// modular_coefficient_alu_core
// Multiply / add / subtract mod p and four-term dot product mod q.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module modular_coefficient_alu_core
  import mca_pkg::*;
#(
  parameter int unsigned DOT_TERMS = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic [MOD_W-1:0]   cfg_wdata_i,
  // input words
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         mode_i,
  input  wire logic signed [31:0] operand_a0_i,
  input  wire logic signed [31:0] operand_b0_i,
  input  wire logic signed [31:0] operand_a1_i,
  input  wire logic signed [31:0] operand_b1_i,
  input  wire logic signed [31:0] operand_a2_i,
  input  wire logic signed [31:0] operand_b2_i,
  input  wire logic signed [31:0] operand_a3_i,
  input  wire logic signed [31:0] operand_b3_i,
  // result words
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      result_o
);

  // term count clamped to the operand pairs that exist
  localparam int unsigned TERMS = (DOT_TERMS < 1) ? 1 :
                                  ((DOT_TERMS > MAX_TERMS) ? MAX_TERMS : DOT_TERMS);
  localparam int unsigned PROD_W = 2 * COEF_W;
  localparam int unsigned SUM_W  = COEF_W + $clog2(TERMS + 1);

  logic en;

  // configuration registers
  logic [MOD_W-1:0] mod_q, dot_mod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q     <= MOD_RESET;
      dot_mod_q <= MOD_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_MODULUS:     mod_q     <= cfg_wdata_i;
        REG_DOT_MODULUS: dot_mod_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // one global advance: a bubble or a taken result frees every stage
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage A: operand capture
  logic               va_q;
  mode_e              mode_a_q;
  logic signed [31:0] a_q [MAX_TERMS];
  logic signed [31:0] b_q [MAX_TERMS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode_a_q <= mode_e'(mode_i);
      a_q[0]   <= operand_a0_i;
      b_q[0]   <= operand_b0_i;
      a_q[1]   <= operand_a1_i;
      b_q[1]   <= operand_b1_i;
      a_q[2]   <= operand_a2_i;
      b_q[2]   <= operand_b2_i;
      a_q[3]   <= operand_a3_i;
      b_q[3]   <= operand_b3_i;
    end
  end

  // stage B: products and the add / subtract result
  logic                      vb_q;
  mode_e                     mode_b_q;
  logic signed [PROD_W-1:0]  prod_q [TERMS];
  logic signed [COEF_W:0]    addsub_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode_b_q <= mode_a_q;
      addsub_q <= (mode_a_q == MODE_SUB) ?
                  (COEF_W+1)'(a_q[0]) - (COEF_W+1)'(b_q[0]) :
                  (COEF_W+1)'(a_q[0]) + (COEF_W+1)'(b_q[0]);
    end
  end

  for (genvar k = 0; k < TERMS; k++) begin : g_mul
    always_ff @(posedge clk_i) begin
      if (en) begin
        prod_q[k] <= PROD_W'(a_q[k]) * PROD_W'(b_q[k]);
      end
    end
  end

  // lane remainders: lane 0 also serves multiply / add / subtract mod p
  logic signed [PROD_W-1:0] lane0_div;
  logic [MOD_W-1:0]         lane0_mod;
  logic [TERMS-1:0]         lane_vld;
  logic [COEF_W-1:0]        lane_rem [TERMS];
  mode_e                    lane_mode [TERMS];

  always_comb begin
    case (mode_b_q) inside
      MODE_ADD, MODE_SUB: lane0_div = PROD_W'(addsub_q);
      default:            lane0_div = prod_q[0];
    endcase
    lane0_mod = (mode_b_q == MODE_DOT) ? dot_mod_q : mod_q;
  end

  for (genvar k = 0; k < TERMS; k++) begin : g_lane
    mca_rem #(
      .W (PROD_W)
    ) u_rem (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .valid_i    (vb_q),
      .dividend_i ((k == 0) ? lane0_div : prod_q[k]),
      .modulus_i  ((k == 0) ? lane0_mod : dot_mod_q),
      .mode_i     (mode_b_q),
      .valid_o    (lane_vld[k]),
      .rem_o      (lane_rem[k]),
      .mode_o     (lane_mode[k])
    );
  end

  // stage C: sum of partial remainders (dot) or pass-through of lane 0
  logic signed [SUM_W-1:0] sum_d;
  logic                    vc_q;
  logic signed [SUM_W-1:0] fin_div_q;
  logic [MOD_W-1:0]        fin_mod_q;
  mode_e                   mode_c_q;

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < TERMS; k++) begin
      sum_d = sum_d + SUM_W'($signed(lane_rem[k]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= lane_vld[0];
    end
  end

  // outside dot mode a zero modulus lets the final unit pass lane 0 through
  always_ff @(posedge clk_i) begin
    if (en) begin
      mode_c_q  <= lane_mode[0];
      fin_div_q <= (lane_mode[0] == MODE_DOT) ? sum_d : SUM_W'($signed(lane_rem[0]));
      fin_mod_q <= (lane_mode[0] == MODE_DOT) ? dot_mod_q : '0;
    end
  end

  logic [COEF_W-1:0] fin_rem;
  mode_e             fin_mode;

  mca_rem #(
    .W (SUM_W)
  ) u_fin (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vc_q),
    .dividend_i (fin_div_q),
    .modulus_i  (fin_mod_q),
    .mode_i     (mode_c_q),
    .valid_o    (out_valid_o),
    .rem_o      (fin_rem),
    .mode_o     (fin_mode)
  );

  assign result_o = fin_rem;

  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
               out_valid_o && $stable(result_o) && $stable(fin_mode))
  `ASSERT_IMPLY(a_lane_sync, lane_vld[0], lane_vld == {TERMS{1'b1}})
  `ASSERT_NEXT(a_stall_blocks_input, !en, $stable(va_q) && $stable(vc_q))

endmodule

`default_nettype wire

[test/modular_coefficient_alu_core_test.sv]
// ---------------------------------------------------------------------------
// modular_coefficient_alu_core_test
// Drives coefficient words with random gaps and stalls, predicts each result
// word with truncating remainders, and checks results in order.
// ---------------------------------------------------------------------------
`default_nettype none

module modular_coefficient_alu_core_test
  import mca_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 106;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [MOD_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] mode_i = '0;
  logic signed [31:0] a_q [4];
  logic signed [31:0] b_q [4];
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] result_o;

  // operand arrays start known
  initial begin
    for (int k = 0; k < 4; k++) begin
      a_q[k] = '0;
      b_q[k] = '0;
    end
  end

  modular_coefficient_alu_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .mode_i,
    .operand_a0_i(a_q[0]), .operand_b0_i(b_q[0]),
    .operand_a1_i(a_q[1]), .operand_b1_i(b_q[1]),
    .operand_a2_i(a_q[2]), .operand_b2_i(b_q[2]),
    .operand_a3_i(a_q[3]), .operand_b3_i(b_q[3]),
    .out_valid_o, .out_ready_i, .result_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the two moduli
  logic [MOD_W-1:0] p_mod = MOD_RESET;
  logic [MOD_W-1:0] q_mod = MOD_RESET;

  logic signed [31:0] coef_expect_q [$];
  int mismatches = 0;
  int results_seen = 0;
  int words_sent = 0;
  int mode_count [4] = '{0, 0, 0, 0};
  longint cycles = 0;
  bit hold_off = 1'b0;   // long receiver stall requested by a test
  bit long_stall_seen = 1'b0;

  // truncating remainder, zero modulus passes the dividend
  function automatic longint trunc_rem(longint x, logic [MOD_W-1:0] m);
    if (m == '0) return x;
    return x % longint'({33'd0, m});
  endfunction

  function automatic logic signed [31:0] coef_predict(logic [1:0] mode,
      logic signed [31:0] a [4], logic signed [31:0] b [4]);
    longint r;
    longint sum;
    sum = 0;
    case (mode_e'(mode))
      MODE_MUL: r = trunc_rem(longint'(a[0]) * longint'(b[0]), p_mod);
      MODE_ADD: r = trunc_rem(longint'(a[0]) + longint'(b[0]), p_mod);
      MODE_SUB: r = trunc_rem(longint'(a[0]) - longint'(b[0]), p_mod);
      default: begin
        for (int k = 0; k < MAX_TERMS; k++)
          sum += trunc_rem(longint'(a[k]) * longint'(b[k]), q_mod);
        r = trunc_rem(sum, q_mod);
      end
    endcase
    return r[31:0];
  endfunction

  // the block is idle here; a write takes effect at the next rising edge
  task automatic write_reg(reg_idx_e idx, logic [MOD_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MODULUS) p_mod = val;
    else q_mod = val;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one word, hold it until taken; valid stays up for a
  // back-to-back word and is dropped by a gap or by wait_idle
  task automatic send_word(logic [1:0] mode, logic signed [31:0] a [4],
      logic signed [31:0] b [4], bit gaps);
    int g;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    for (int k = 0; k < 4; k++) begin
      a_q[k] <= a[k];
      b_q[k] <= b[k];
    end
    do @(posedge clk_i); while (!in_ready_o);
    coef_expect_q.push_back(coef_predict(mode, a, b));
    words_sent++;
    mode_count[mode]++;
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 20)) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [MOD_W-1:0] rand_modulus();
    case ($urandom_range(0, 4))
      0: return 31'h7fffffff;
      1: return MOD_W'($urandom_range(1, 17));
      2: return MOD_RESET;
      default: return MOD_W'($urandom);
    endcase
  endfunction

  // called at a falling edge; drops valid and drains the pipeline
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (coef_expect_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // extremes of every operand under each mode and the current moduli
  task automatic test_directed();
    logic signed [31:0] a [4];
    logic signed [31:0] b [4];
    logic signed [31:0] vals [5] = '{32'sh7fffffff, 32'sh80000000, -1, 0, 1};
    for (int m = 0; m < 4; m++) begin
      for (int i = 0; i < 5; i++) begin
        for (int k = 0; k < 4; k++) begin
          a[k] = vals[i];
          b[k] = vals[(i + k + 1) % 5];
        end
        send_word(m[1:0], a, b, 1'b0);
      end
    end
  endtask

  task automatic test_random(int n);
    logic signed [31:0] a [4];
    logic signed [31:0] b [4];
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 4; k++) begin
        a[k] = rand_operand();
        b[k] = rand_operand();
      end
      send_word(2'($urandom_range(0, 3)), a, b, 1'b1);
    end
  endtask

  // zero modulus passes values through; small and largest moduli
  task automatic test_moduli();
    write_reg(REG_MODULUS, '0);
    write_reg(REG_DOT_MODULUS, '0);
    test_directed();
    test_random(150);
    wait_idle();
    write_reg(REG_MODULUS, 31'h7fffffff);
    write_reg(REG_DOT_MODULUS, 31'd1);
    test_directed();
    test_random(150);
    wait_idle();
    write_reg(REG_MODULUS, 31'd1);
    write_reg(REG_DOT_MODULUS, 31'h7fffffff);
    test_random(150);
    wait_idle();
  endtask

  task automatic test_random_configs();
    for (int s = 0; s < 6; s++) begin
      write_reg(REG_MODULUS, rand_modulus());
      write_reg(REG_DOT_MODULUS, rand_modulus());
      test_random(100);
      wait_idle();
    end
  endtask

  // receiver stalls long while words keep coming, so the pipeline fills
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      test_random(300);
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    wait_idle();
  endtask

  // receiver: random stall lengths, plus the long hold-off
  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        long_stall_seen = 1'b1;
      end else begin
        g = pick_gap();
        if (g == 0) out_ready_i <= 1'b1;
        else begin
          out_ready_i <= 1'b0;
          repeat (g - 1) @(negedge clk_i);
        end
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    logic signed [31:0] exp_v;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (coef_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %0d", result_o);
      end else begin
        exp_v = coef_expect_q.pop_front();
        if (result_o !== exp_v) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %0d got %0d", exp_v, result_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("modular_coefficient_alu_core_test: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();     // reset moduli
    test_random(150);
    wait_idle();
    test_moduli();
    test_random_configs();
    test_backpressure();
    if (coef_expect_q.size() != 0) begin
      mismatches++;
      $display("%0d result words never arrived", coef_expect_q.size());
    end
    $display("covered %0d words (mul %0d add %0d sub %0d dot %0d), %0d results",
             words_sent, mode_count[0], mode_count[1], mode_count[2],
             mode_count[3], results_seen);
    $display("moduli zero, one, small, max and random; long output stall %0s",
             long_stall_seen ? "done" : "missing");
    if (mismatches == 0) $display("modular_coefficient_alu_core_test: PASS");
    else $display("modular_coefficient_alu_core_test: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
